FILE: design/lgit_pkg.sv
// Shared types and constants for the landmark gated insert table.
// Used by every module of the block but lgit_ram; depends on nothing.
package lgit_pkg;

  // Default sizing of the table and of the coordinates.
  localparam int CAPACITY_DEFAULT   = 32;
  localparam int COORD_BITS_DEFAULT = 16;

  // Fixed field widths of the result and the configuration port.
  localparam int RADIUS_BITS = 16;
  localparam int INDEX_BITS  = 5;
  localparam int COUNT_BITS  = 6;
  localparam int PADDR_BITS  = 3;
  localparam int PDATA_BITS  = 32;

  // Reset value of the gate radius: 1.0 m in Q8.8.
  localparam logic [RADIUS_BITS-1:0] GATE_RADIUS_RESET = 16'd256;

  // Register index of the gate radius.
  localparam logic REG_GATE_RADIUS = 1'b0;

  typedef logic [INDEX_BITS-1:0] index_t;
  typedef logic [COUNT_BITS-1:0] count_t;

  // Kind of an accepted item.
  typedef enum logic {
    KIND_OBSERVE = 1'b0,
    KIND_CLEAR   = 1'b1
  } item_kind_t;

  // Outcome codes of a result.
  typedef enum logic [1:0] {
    STATUS_APPENDED = 2'd0,
    STATUS_MATCHED  = 2'd1,
    STATUS_DROPPED  = 2'd2,
    STATUS_CLEARED  = 2'd3
  } status_t;

  // States of the back-end sequencer.
  typedef enum logic {
    BACK_IDLE = 1'b0,
    BACK_SCAN = 1'b1
  } back_state_t;

  // Control part of an item that travels through the queue.
  typedef struct packed {
    item_kind_t kind;
    logic       batch_last;
  } item_ctl_t;

  // One result item.
  typedef struct packed {
    status_t status;
    index_t  index;
    count_t  count;
    logic    batch_done;
  } result_t;

endpackage

FILE: design/lgit_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
// Depends on nothing.
module lgit_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: design/lgit_front.sv
// Front end: accepts commands, classifies them and holds them in a two-entry queue.
// Depends on lgit_pkg.
module lgit_front #(
  parameter int COORD_BITS = lgit_pkg::COORD_BITS_DEFAULT
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  output logic                   busy,
  input  logic                   operation,
  input  logic [COORD_BITS-1:0]  landmark_x,
  input  logic [COORD_BITS-1:0]  landmark_y,
  input  logic                   batch_last,
  output logic                   head_valid,
  output lgit_pkg::item_ctl_t    head_ctl,
  output logic [COORD_BITS-1:0]  head_x,
  output logic [COORD_BITS-1:0]  head_y,
  input  logic                   pop
);

  lgit_pkg::item_ctl_t         q_ctl [2];
  logic [COORD_BITS-1:0]       q_x   [2];
  logic [COORD_BITS-1:0]       q_y   [2];
  logic                        wr_ptr;
  logic                        rd_ptr;
  logic [1:0]                  fill;
  logic                        push;
  lgit_pkg::item_ctl_t         in_ctl;

  // A command transfer happens while the queue has room.
  assign busy = (fill == 2'd2);
  assign push = start && !busy;

  // Classify the command.
  always_comb begin
    in_ctl.kind       = operation ? lgit_pkg::KIND_CLEAR : lgit_pkg::KIND_OBSERVE;
    in_ctl.batch_last = batch_last;
  end

  // Queue storage.
  always_ff @(posedge clk) begin
    if (push) begin
      q_ctl[wr_ptr] <= in_ctl;
      q_x[wr_ptr]   <= landmark_x;
      q_y[wr_ptr]   <= landmark_y;
    end
  end

  // Queue pointers and occupancy.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      fill <= fill + {1'b0, push} - {1'b0, pop};
    end
  end

  assign head_valid = (fill != 2'd0);
  assign head_ctl   = q_ctl[rd_ptr];
  assign head_x     = q_x[rd_ptr];
  assign head_y     = q_y[rd_ptr];

endmodule

FILE: design/lgit_gate.sv
// Pipelined squared-distance gate test, three register stages deep.
// Depends on lgit_pkg.
module lgit_gate #(
  parameter int COORD_BITS = lgit_pkg::COORD_BITS_DEFAULT,
  parameter int TAG_BITS   = 5
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             flush,
  input  logic [lgit_pkg::RADIUS_BITS-1:0] gate_radius,
  input  logic                             in_valid,
  input  logic [TAG_BITS-1:0]              in_tag,
  input  logic [COORD_BITS-1:0]            ax,
  input  logic [COORD_BITS-1:0]            ay,
  input  logic [COORD_BITS-1:0]            bx,
  input  logic [COORD_BITS-1:0]            by,
  output logic                             out_valid,
  output logic [TAG_BITS-1:0]              out_tag,
  output logic                             out_hit,
  output logic                             busy
);

  localparam int RB = lgit_pkg::RADIUS_BITS;
  localparam int DB = COORD_BITS + 1;
  localparam int CW = (DB > RB) ? DB : RB;

  logic signed [DB-1:0] diff_x;
  logic signed [DB-1:0] diff_y;
  logic [DB-1:0]        abs_x;
  logic [DB-1:0]        abs_y;
  logic [CW-1:0]        abs_x_w;
  logic [CW-1:0]        abs_y_w;
  logic [CW-1:0]        radius_w;

  logic                 v1;
  logic [TAG_BITS-1:0]  tag1;
  logic                 over1;
  logic [RB-1:0]        dx1;
  logic [RB-1:0]        dy1;

  logic                 v2;
  logic [TAG_BITS-1:0]  tag2;
  logic                 over2;
  logic [2*RB-1:0]      sqx2;
  logic [2*RB-1:0]      sqy2;

  logic [2*RB-1:0]      rsq;
  logic [2*RB:0]        dist_sq;

  // Exact absolute differences with one guard bit.
  always_comb begin
    diff_x   = $signed({ax[COORD_BITS-1], ax}) - $signed({bx[COORD_BITS-1], bx});
    diff_y   = $signed({ay[COORD_BITS-1], ay}) - $signed({by[COORD_BITS-1], by});
    abs_x    = diff_x[DB-1] ? DB'(-diff_x) : DB'(diff_x);
    abs_y    = diff_y[DB-1] ? DB'(-diff_y) : DB'(diff_y);
    abs_x_w  = CW'(abs_x);
    abs_y_w  = CW'(abs_y);
    radius_w = CW'(gate_radius);
  end

  // Squared radius, refreshed every cycle from the register.
  always_ff @(posedge clk) begin
    rsq <= (2*RB)'(gate_radius) * (2*RB)'(gate_radius);
  end

  // Stage payloads: per-axis range test, then squares.
  always_ff @(posedge clk) begin
    tag1  <= in_tag;
    over1 <= (abs_x_w > radius_w) || (abs_y_w > radius_w);
    dx1   <= abs_x_w[RB-1:0];
    dy1   <= abs_y_w[RB-1:0];
    tag2  <= tag1;
    over2 <= over1;
    sqx2  <= (2*RB)'(dx1) * (2*RB)'(dx1);
    sqy2  <= (2*RB)'(dy1) * (2*RB)'(dy1);
    out_tag <= tag2;
    out_hit <= !over2 && (dist_sq <= {1'b0, rsq});
  end

  assign dist_sq = {1'b0, sqx2} + {1'b0, sqy2};

  // Stage valid bits, cleared on reset and when the scan ends.
  always_ff @(posedge clk) begin
    if (rst || flush) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      v1        <= in_valid;
      v2        <= v1;
      out_valid <= v2;
    end
  end

  assign busy = v1 || v2 || out_valid;

endmodule

FILE: design/lgit_back.sv
// Back end: clears the table on a clear, or scans it one entry per cycle, then matches, appends or drops.
// Depends on lgit_pkg, lgit_ram and lgit_gate.
module lgit_back #(
  parameter int CAPACITY   = lgit_pkg::CAPACITY_DEFAULT,
  parameter int COORD_BITS = lgit_pkg::COORD_BITS_DEFAULT
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic [lgit_pkg::RADIUS_BITS-1:0] gate_radius,
  input  logic                             head_valid,
  input  lgit_pkg::item_ctl_t              head_ctl,
  input  logic [COORD_BITS-1:0]            head_x,
  input  logic [COORD_BITS-1:0]            head_y,
  output logic                             pop,
  output logic                             res_valid,
  output lgit_pkg::result_t                res
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam logic [CW-1:0] CAP_COUNT = CW'(CAPACITY);

  lgit_pkg::back_state_t   state;
  lgit_pkg::back_state_t   state_next;
  logic [CW-1:0]           fill;
  logic [CW-1:0]           fill_next;
  logic [CW-1:0]           issue_idx;
  logic [CW-1:0]           issue_idx_next;
  logic                    rd_valid;
  logic [AW-1:0]           rd_tag;
  logic                    cur_batch;
  logic [COORD_BITS-1:0]   cur_x;
  logic [COORD_BITS-1:0]   cur_y;
  lgit_pkg::result_t       res_next;
  logic                    res_valid_next;

  logic                    load;
  logic                    issue;
  logic                    finish;
  logic                    ram_we;
  logic [2*COORD_BITS-1:0] ram_rdata;
  logic                    g_valid;
  logic [AW-1:0]           g_tag;
  logic                    g_hit;
  logic                    g_busy;

  // Table storage: x in the upper half, y in the lower half.
  lgit_ram #(
    .WIDTH (2 * COORD_BITS),
    .DEPTH (CAPACITY)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (fill[AW-1:0]),
    .wdata ({cur_x, cur_y}),
    .re    (issue),
    .raddr (issue_idx[AW-1:0]),
    .rdata (ram_rdata)
  );

  // Distance test on each entry read back.
  lgit_gate #(
    .COORD_BITS (COORD_BITS),
    .TAG_BITS   (AW)
  ) u_gate (
    .clk         (clk),
    .rst         (rst),
    .flush       (finish),
    .gate_radius (gate_radius),
    .in_valid    (rd_valid),
    .in_tag      (rd_tag),
    .ax          (ram_rdata[2*COORD_BITS-1:COORD_BITS]),
    .ay          (ram_rdata[COORD_BITS-1:0]),
    .bx          (cur_x),
    .by          (cur_y),
    .out_valid   (g_valid),
    .out_tag     (g_tag),
    .out_hit     (g_hit),
    .busy        (g_busy)
  );

  // Sequencer: next state, table updates and result.
  always_comb begin
    state_next     = state;
    fill_next      = fill;
    issue_idx_next = issue_idx;
    res_next       = res;
    res_valid_next = 1'b0;
    pop            = 1'b0;
    load           = 1'b0;
    issue          = 1'b0;
    finish         = 1'b0;
    ram_we         = 1'b0;
    unique case (state)
      lgit_pkg::BACK_IDLE: begin
        if (head_valid) begin
          pop = 1'b1;
          if (head_ctl.kind == lgit_pkg::KIND_CLEAR) begin
            fill_next           = '0;
            res_valid_next      = 1'b1;
            res_next.status     = lgit_pkg::STATUS_CLEARED;
            res_next.index      = '0;
            res_next.count      = '0;
            res_next.batch_done = head_ctl.batch_last;
          end else begin
            load           = 1'b1;
            issue_idx_next = '0;
            state_next     = lgit_pkg::BACK_SCAN;
          end
        end
      end
      lgit_pkg::BACK_SCAN: begin
        priority if (g_valid && g_hit) begin
          // First hit in index order wins.
          finish              = 1'b1;
          res_valid_next      = 1'b1;
          res_next.status     = lgit_pkg::STATUS_MATCHED;
          res_next.index      = lgit_pkg::index_t'(g_tag);
          res_next.count      = lgit_pkg::count_t'(fill);
          res_next.batch_done = cur_batch;
        end else if ((issue_idx == fill) && !rd_valid && !g_busy) begin
          // Every entry checked without a hit.
          finish              = 1'b1;
          res_valid_next      = 1'b1;
          res_next.batch_done = cur_batch;
          if (fill < CAP_COUNT) begin
            ram_we          = 1'b1;
            fill_next       = fill + CW'(1);
            res_next.status = lgit_pkg::STATUS_APPENDED;
            res_next.index  = lgit_pkg::index_t'(fill);
            res_next.count  = lgit_pkg::count_t'(fill + CW'(1));
          end else begin
            res_next.status = lgit_pkg::STATUS_DROPPED;
            res_next.index  = '0;
            res_next.count  = lgit_pkg::count_t'(fill);
          end
        end else if (issue_idx < fill) begin
          issue          = 1'b1;
          issue_idx_next = issue_idx + CW'(1);
        end else begin
          issue = 1'b0;
        end
        if (finish) begin
          state_next = lgit_pkg::BACK_IDLE;
        end
      end
      default: begin
        state_next = lgit_pkg::BACK_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= lgit_pkg::BACK_IDLE;
      fill      <= '0;
      issue_idx <= '0;
      rd_valid  <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      state     <= state_next;
      fill      <= fill_next;
      issue_idx <= issue_idx_next;
      rd_valid  <= issue;
      res_valid <= res_valid_next;
    end
  end

  // Payload registers: current item, read tag and result fields.
  always_ff @(posedge clk) begin
    if (load) begin
      cur_x     <= head_x;
      cur_y     <= head_y;
      cur_batch <= head_ctl.batch_last;
    end
    rd_tag <= issue_idx[AW-1:0];
    res    <= res_next;
  end

endmodule

FILE: design/landmark_gated_insert_table.sv
// Landmark gated insert table: command front end, queue and scanning back end.
// An observe scans the table one entry per cycle through the 3-stage gate, then matches the
// first hit, appends, or drops the item on a full table; a clear empties the table.
// Items are handled one at a time; a two-entry queue takes commands during a scan.
// Reset empties the table and the queue and sets the gate radius to 1.0 m.
// Results appear for one cycle on done; the receiver cannot stall them.
module landmark_gated_insert_table #(
  parameter int CAPACITY   = lgit_pkg::CAPACITY_DEFAULT,
  parameter int COORD_BITS = lgit_pkg::COORD_BITS_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  logic                            operation,
  input  logic [COORD_BITS-1:0]           landmark_x,
  input  logic [COORD_BITS-1:0]           landmark_y,
  input  logic                            batch_last,
  output logic                            done,
  output logic [1:0]                      status,
  output logic [lgit_pkg::INDEX_BITS-1:0] entry_index,
  output logic [lgit_pkg::COUNT_BITS-1:0] entry_count,
  output logic                            batch_done,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [lgit_pkg::PADDR_BITS-1:0] paddr,
  input  logic [lgit_pkg::PDATA_BITS-1:0] pwdata,
  output logic [lgit_pkg::PDATA_BITS-1:0] prdata,
  output logic                            pready
);

  localparam int RB = lgit_pkg::RADIUS_BITS;

  logic [RB-1:0]          gate_radius;
  logic                   reg_sel;
  logic                   head_valid;
  lgit_pkg::item_ctl_t    head_ctl;
  logic [COORD_BITS-1:0]  head_x;
  logic [COORD_BITS-1:0]  head_y;
  logic                   pop;
  lgit_pkg::result_t      res;

  // Configuration register; the word index sits above the byte offset.
  assign pready  = 1'b1;
  assign reg_sel = (paddr[2] == lgit_pkg::REG_GATE_RADIUS);

  always_ff @(posedge clk) begin
    if (rst) begin
      gate_radius <= lgit_pkg::GATE_RADIUS_RESET;
    end else if (psel && penable && pwrite && reg_sel) begin
      gate_radius <= pwdata[RB-1:0];
    end
  end

  assign prdata = reg_sel ? {{(lgit_pkg::PDATA_BITS - RB){1'b0}}, gate_radius} : '0;

  lgit_front #(
    .COORD_BITS (COORD_BITS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .operation  (operation),
    .landmark_x (landmark_x),
    .landmark_y (landmark_y),
    .batch_last (batch_last),
    .head_valid (head_valid),
    .head_ctl   (head_ctl),
    .head_x     (head_x),
    .head_y     (head_y),
    .pop        (pop)
  );

  lgit_back #(
    .CAPACITY   (CAPACITY),
    .COORD_BITS (COORD_BITS)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .gate_radius (gate_radius),
    .head_valid  (head_valid),
    .head_ctl    (head_ctl),
    .head_x      (head_x),
    .head_y      (head_y),
    .pop         (pop),
    .res_valid   (done),
    .res         (res)
  );

  // Result fields.
  assign status      = res.status;
  assign entry_index = res.index;
  assign entry_count = res.count;
  assign batch_done  = res.batch_done;

endmodule
